FILE: rtl/core/tlqs_pkg.sv
// Shared types and constants for the three-level queue scheduler.
// No dependencies.
package tlqs_pkg;

	localparam int NCLASS      = 3;
	localparam int CLASS_W     = 2;
	localparam int QUANTUM_W   = 4;
	localparam int PORT_ID_W   = 16;
	localparam int PORT_LEN_W  = 16;
	localparam int TIME_W      = 32;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM_HIGH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM_MID  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM_LOW  = 2'd2;

	localparam logic [CLASS_W-1:0] CLASS_HIGH = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_MID  = 2'd1;

	localparam logic [QUANTUM_W-1:0] SLICE_MAX = 4'd15;

	// One result transaction.
	typedef struct packed {
		logic                  dropped;
		logic                  done_res;
		logic [CLASS_W-1:0]    run_class;
		logic                  run_valid;
		logic [TIME_W-1:0]     now;
		logic [PORT_ID_W-1:0]  run_id;
	} result_t;

endpackage

FILE: rtl/core/tlqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tlqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/three_level_queue_scheduler_top.sv
// Three-level queue scheduler, top level: tick sequencer around one job RAM.
// Depends on tlqs_pkg and tlqs_ram.
//
// Each input transaction is one scheduler tick; each tick yields exactly one
// result transaction. The three class FIFOs share one RAM of 3*QUEUE_DEPTH
// entries (id and remaining length); heads and counts sit in flip-flops.
// A tick is worked through a sequencer: arrival push, then up to three job
// takes, each a registered RAM read, plus requeue writes. The single RAM read
// port serialises the takes: each take runs through the states TAKE and TDAT
// in turn, after a rotation, a preemption or a retirement.
// A new tick is accepted while the previous result still waits at the output
// register.
module three_level_queue_scheduler_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16,
	parameter int LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // arrival_id, arrival_length
	input  logic [2:0]  s_tuser,   // arrival_valid, arrival_class
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // run_id, now
	output logic [4:0]  m_tuser    // run_valid, run_class, done_res, dropped
);

	localparam int NC     = tlqs_pkg::NCLASS;
	localparam int CW     = tlqs_pkg::CLASS_W;
	localparam int QW     = tlqs_pkg::QUANTUM_W;
	localparam int TW     = tlqs_pkg::TIME_W;
	localparam int HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW     = $clog2(QUEUE_DEPTH + 1);
	localparam int RDEPTH = NC * QUEUE_DEPTH;
	localparam int AW     = $clog2(RDEPTH);
	localparam int EW     = ID_BITS + LENGTH_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ARR  = 3'd1;
	localparam logic [2:0] ST_ROT  = 3'd2;
	localparam logic [2:0] ST_PRE  = 3'd3;
	localparam logic [2:0] ST_RUN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam logic [2:0] ST_TAKE = 3'd6;
	localparam logic [2:0] ST_TDAT = 3'd7;

	localparam logic [NW-1:0] DEPTH_N = NW'(QUEUE_DEPTH);
	localparam logic [HW-1:0] LAST_H  = HW'(QUEUE_DEPTH - 1);

	logic [2:0]             state_q, ret_q;
	logic [QW-1:0]          qh_q, qm_q, ql_q;
	logic [HW-1:0]          head_q [NC];
	logic [NW-1:0]          count_q [NC];
	logic                   run_v_q;
	logic [ID_BITS-1:0]     run_id_q;
	logic [LENGTH_BITS-1:0] run_rem_q;
	logic [CW-1:0]          run_cls_q;
	logic [QW-1:0]          slice_q;
	logic [TW-1:0]          time_q;
	logic                   a_valid_q, arrived_q, dropped_q;
	logic [CW-1:0]          a_cls_q;
	logic [ID_BITS-1:0]     a_id_q;
	logic [LENGTH_BITS-1:0] a_len_q;
	tlqs_pkg::result_t      res_q, out_q;
	logic                   out_v_q;

	logic                   we, re;
	logic [AW-1:0]          waddr, raddr;
	logic [EW-1:0]          wdata, rdata;

	logic                   any_ne;
	logic [CW-1:0]          first_ne;
	logic [QW-1:0]          quantum;
	logic [HW-1:0]          rot_head;

	function automatic logic [AW-1:0] slot(input logic [CW-1:0] c, input logic [HW-1:0] h,
		input logic [NW-1:0] n);
		logic [AW+NW:0] s;
		s = (AW+NW+1)'(c) * (AW+NW+1)'(QUEUE_DEPTH) + (AW+NW+1)'(h) + (AW+NW+1)'(n);
		if (s[AW+NW:0] >= (AW+NW+1)'(c) * (AW+NW+1)'(QUEUE_DEPTH) + (AW+NW+1)'(QUEUE_DEPTH)) begin
			s = s - (AW+NW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	always_comb begin
		any_ne   = 1'b0;
		first_ne = '0;
		for (int c = NC - 1; c >= 0; c--) begin
			if (count_q[c] != '0) begin
				any_ne   = 1'b1;
				first_ne = CW'(c);
			end
		end
	end

	always_comb begin
		case (run_cls_q)
			tlqs_pkg::CLASS_HIGH: quantum = qh_q;
			tlqs_pkg::CLASS_MID:  quantum = qm_q;
			default:              quantum = ql_q;
		endcase
		if (quantum == '0) begin
			quantum = QW'(1);
		end
	end

	assign rot_head = (head_q[first_ne] == LAST_H) ? '0 : head_q[first_ne] + HW'(1);

	// RAM port control
	always_comb begin
		we    = 1'b0;
		wdata = {a_len_q, a_id_q};
		waddr = slot(a_cls_q, head_q[a_cls_q], count_q[a_cls_q]);
		if (state_q == ST_ARR) begin
			we = a_valid_q && (count_q[a_cls_q] < DEPTH_N);
		end else if ((state_q == ST_ROT || state_q == ST_PRE) && run_v_q) begin
			wdata = {run_rem_q, run_id_q};
			waddr = slot(run_cls_q, head_q[run_cls_q], count_q[run_cls_q]);
			if (state_q == ST_ROT) begin
				we = (slice_q >= quantum) && (count_q[run_cls_q] < DEPTH_N);
			end else begin
				we = arrived_q && (run_cls_q > a_cls_q) && (count_q[run_cls_q] < DEPTH_N);
			end
		end
		re    = (state_q == ST_TAKE) && any_ne;
		raddr = slot(first_ne, head_q[first_ne], '0);
	end

	tlqs_ram #(
		.WIDTH(EW),
		.DEPTH(RDEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.now, out_q.run_id};
	assign m_tuser  = {out_q.dropped, out_q.done_res, out_q.run_class, out_q.run_valid};

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			a_cls_q <= s_tuser[2:1];
			a_id_q  <= ID_BITS'({16'd0, s_tdata[15:0]});
			a_len_q <= LENGTH_BITS'({16'd0, s_tdata[31:16]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= ST_ROT;
			qh_q      <= 4'd2;
			qm_q      <= 4'd4;
			ql_q      <= 4'd8;
			for (int c = 0; c < NC; c++) begin
				head_q[c]  <= '0;
				count_q[c] <= '0;
			end
			run_v_q   <= 1'b0;
			run_id_q  <= '0;
			run_rem_q <= '0;
			run_cls_q <= '0;
			slice_q   <= '0;
			time_q    <= '0;
			a_valid_q <= 1'b0;
			arrived_q <= 1'b0;
			dropped_q <= 1'b0;
			res_q     <= '0;
			out_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tlqs_pkg::CFG_QUANTUM_HIGH: qh_q <= cfg_data;
					tlqs_pkg::CFG_QUANTUM_MID:  qm_q <= cfg_data;
					tlqs_pkg::CFG_QUANTUM_LOW:  ql_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && (!out_v_q || m_tready)) begin
				out_v_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						a_valid_q <= s_tuser[0] && (s_tuser[2:1] != 2'd3);
						state_q   <= ST_ARR;
					end
				end
				ST_ARR: begin
					arrived_q <= 1'b0;
					dropped_q <= 1'b0;
					if (a_valid_q) begin
						if (count_q[a_cls_q] < DEPTH_N) begin
							count_q[a_cls_q] <= count_q[a_cls_q] + NW'(1);
							arrived_q        <= 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
					end
					ret_q   <= ST_ROT;
					state_q <= run_v_q ? ST_ROT : ST_TAKE;
				end
				ST_ROT, ST_PRE: begin
					if (we) begin
						count_q[run_cls_q] <= count_q[run_cls_q] + NW'(1);
						ret_q   <= (state_q == ST_ROT) ? ST_PRE : ST_RUN;
						state_q <= ST_TAKE;
					end else begin
						// requeue wanted but FIFO full: keep running, restart slice
						if (run_v_q && ((state_q == ST_ROT) ? (slice_q >= quantum)
							: (arrived_q && run_cls_q > a_cls_q))) begin
							slice_q <= '0;
						end
						state_q <= (state_q == ST_ROT) ? ST_PRE : ST_RUN;
					end
				end
				ST_RUN: begin
					time_q <= time_q + TW'(1);
					if (slice_q < tlqs_pkg::SLICE_MAX) begin
						slice_q <= slice_q + QW'(1);
					end
					res_q.run_valid <= run_v_q;
					res_q.run_id    <= tlqs_pkg::PORT_ID_W'({32'd0, run_id_q});
					res_q.run_class <= run_cls_q;
					res_q.done_res  <= run_v_q && (run_rem_q <= LENGTH_BITS'(1));
					res_q.dropped   <= dropped_q;
					res_q.now       <= time_q + TW'(1);
					ret_q <= ST_OUT;
					if (run_v_q && run_rem_q > LENGTH_BITS'(1)) begin
						run_rem_q <= run_rem_q - LENGTH_BITS'(1);
						state_q   <= ST_OUT;
					end else begin
						run_rem_q <= '0;
						state_q   <= run_v_q ? ST_TAKE : ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_v_q || m_tready) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				ST_TAKE: begin
					slice_q <= '0;
					if (any_ne) begin
						head_q[first_ne]  <= rot_head;
						count_q[first_ne] <= count_q[first_ne] - NW'(1);
						run_cls_q         <= first_ne;
						state_q           <= ST_TDAT;
					end else begin
						run_v_q   <= 1'b0;
						run_id_q  <= '0;
						run_rem_q <= '0;
						run_cls_q <= '0;
						state_q   <= ret_q;
					end
				end
				ST_TDAT: begin
					run_v_q   <= 1'b1;
					run_id_q  <= rdata[ID_BITS-1:0];
					run_rem_q <= rdata[EW-1:ID_BITS];
					state_q   <= ret_q;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	for (genvar g = 0; g < NC; g++) begin : g_chk
		a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[g] <= DEPTH_N)
			else $error("FIFO count beyond depth");
	end

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_TAKE || state_q == ST_TDAT) |-> !we)
		else $error("RAM write outside push states");

	a_take_sets_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TDAT) |=> run_v_q)
		else $error("job take did not start a job");

	a_run_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> (state_q == ST_OUT || state_q == ST_TAKE))
		else $error("tick left run without result");

endmodule

FILE: sim/tlqs_checker.sv
`timescale 1ns / 100ps
// Checker for the three-level queue scheduler: predicts each tick result.
// Depends on tlqs_pkg; watches the stream ports and the configuration port.
module tlqs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [4:0]  m_tuser,
	output int          fail_count,
	output int          pending,
	output int          result_count
);

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] rem;
	} job_t;

	typedef struct packed {
		logic        dropped;
		logic        done_res;
		logic [1:0]  run_class;
		logic        run_valid;
		logic [31:0] now;
		logic [15:0] run_id;
	} tick_result_t;

	job_t        fifo [tlqs_pkg::NCLASS][DEPTH];
	int          head [tlqs_pkg::NCLASS];
	int          count [tlqs_pkg::NCLASS];
	logic        busy;
	job_t        cur;
	int          cur_class;
	int          slice;
	logic [31:0] ticks;
	logic [3:0]  quantum [tlqs_pkg::NCLASS];
	tick_result_t expected_ticks [$];

	assign pending = expected_ticks.size();

	function automatic bit push_job(int c, job_t j);
		if (c >= tlqs_pkg::NCLASS || count[c] >= DEPTH)
			return 0;
		fifo[c][(head[c] + count[c]) % DEPTH] = j;
		count[c]++;
		return 1;
	endfunction

	function automatic void take_next();
		slice = 0;
		busy = 0;
		cur = '0;
		cur_class = 0;
		for (int c = 0; c < tlqs_pkg::NCLASS; c++) begin
			if (count[c] != 0) begin
				cur = fifo[c][head[c]];
				head[c] = (head[c] + 1) % DEPTH;
				count[c]--;
				cur_class = c;
				busy = 1;
				return;
			end
		end
	endfunction

	function automatic void requeue();
		if (push_job(cur_class, cur))
			take_next();
		else
			slice = 0;
	endfunction

	function automatic tick_result_t schedule_tick(logic [2:0] user, logic [31:0] data);
		tick_result_t r;
		bit   arrived;
		bit   drop;
		bit   fin;
		int   acls;
		int   q;
		job_t j;
		arrived = 0;
		drop = 0;
		fin = 0;
		acls = int'(user[2:1]);
		if (user[0] && acls < tlqs_pkg::NCLASS) begin
			j.id = data[15:0];
			j.rem = data[31:16];
			if (push_job(acls, j))
				arrived = 1;
			else
				drop = 1;
		end
		if (!busy)
			take_next();
		q = (quantum[cur_class] == 0) ? 1 : int'(quantum[cur_class]);
		if (busy && slice >= q)
			requeue();
		if (arrived && busy && cur_class > acls)
			requeue();
		ticks++;
		if (slice < tlqs_pkg::SLICE_MAX)
			slice++;
		r = '0;
		r.run_valid = busy;
		r.run_id = busy ? cur.id : '0;
		r.run_class = busy ? cur_class[1:0] : '0;
		if (busy) begin
			if (cur.rem > 1)
				cur.rem--;
			else begin
				cur.rem = 0;
				fin = 1;
			end
		end
		r.done_res = fin;
		r.dropped = drop;
		r.now = ticks;
		if (fin)
			take_next();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t e;
		tick_result_t a;
		if (!arst_n) begin
			for (int c = 0; c < tlqs_pkg::NCLASS; c++) begin
				head[c] = 0;
				count[c] = 0;
			end
			busy = 0;
			cur = '0;
			cur_class = 0;
			slice = 0;
			ticks = 0;
			quantum[0] = 4'd2;
			quantum[1] = 4'd4;
			quantum[2] = 4'd8;
			expected_ticks.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			if (cfg_we && cfg_index < tlqs_pkg::NCLASS)
				quantum[cfg_index] = cfg_data;
			if (m_tvalid && m_tready) begin
				a.run_id = m_tdata[15:0];
				a.now = m_tdata[47:16];
				a.run_valid = m_tuser[0];
				a.run_class = m_tuser[2:1];
				a.done_res = m_tuser[3];
				a.dropped = m_tuser[4];
				result_count++;
				if (expected_ticks.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result %h", $time, a);
				end else begin
					e = expected_ticks.pop_front();
					if (e.run_valid != a.run_valid || e.run_id != a.run_id ||
						e.run_class != a.run_class || e.done_res != a.done_res ||
						e.dropped != a.dropped || e.now != a.now) begin
						fail_count++;
						$display("%0t: mismatch expected v%0d id%h c%0d d%0d x%0d t%0d",
							$time, e.run_valid, e.run_id, e.run_class, e.done_res,
							e.dropped, e.now);
						$display("%0t:          actual v%0d id%h c%0d d%0d x%0d t%0d",
							$time, a.run_valid, a.run_id, a.run_class, a.done_res,
							a.dropped, a.now);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_ticks.push_back(schedule_tick(s_tuser, s_tdata));
		end
	end

endmodule

FILE: sim/three_level_queue_scheduler_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the three-level queue scheduler: clock, reset, stimulus.
// Depends on tlqs_pkg, tlqs_checker and the scheduler RTL.
module three_level_queue_scheduler_top_tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [3:0]  cfg_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // arrival_id, arrival_length
	logic [2:0]  s_tuser = '0;   // arrival_valid, arrival_class
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;        // run_id, now
	logic [4:0]  m_tuser;        // run_valid, run_class, done_res, dropped
	int          fail_count;
	int          pending;
	int          result_count;
	int          tick_count = 0;
	bit          sink_hold = 0;

	always #10 clk = ~clk;

	three_level_queue_scheduler_top dut (.*);

	tlqs_checker checker_i (.*);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	task automatic write_quantum(logic [1:0] idx, logic [3:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain_results();
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_tick(bit av, logic [1:0] cls, logic [15:0] id, logic [15:0] len,
		bit no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g != 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= {cls, av};
		s_tdata <= {len, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tick_count++;
	endtask

	// Mostly short jobs so that queues cycle; a few long ones and class three noise.
	task automatic random_tick(bit no_gap);
		logic [15:0] len;
		logic [1:0]  cls;
		case ($urandom_range(0, 9))
			0: len = 16'($urandom);
			1: len = 0;
			default: len = 16'($urandom_range(1, 12));
		endcase
		cls = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		send_tick($urandom_range(0, 2) != 0, cls, 16'($urandom), len, no_gap);
	endtask

	// Receiver: random stalls, or a long hold-off on request.
	initial begin
		int g;
		forever begin
			if (sink_hold) begin
				m_tready <= 0;
				repeat (300) @(posedge clk);
				sink_hold = 0;
			end
			g = gap_len();
			if (g != 0) begin
				m_tready <= 0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	initial begin
		#50000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [3:0] qsets [4][3];
		qsets[0] = '{4'd2, 4'd4, 4'd8};
		qsets[1] = '{4'd1, 4'd1, 4'd1};
		qsets[2] = '{4'd15, 4'd15, 4'd15};
		qsets[3] = '{4'd0, 4'd7, 4'd3};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_quantum(tlqs_pkg::CFG_QUANTUM_HIGH, 4'd2);
		write_quantum(tlqs_pkg::CFG_QUANTUM_MID, 4'd4);
		write_quantum(tlqs_pkg::CFG_QUANTUM_LOW, 4'd8);

		// Directed: empty tick, extremes, preemption, class three, zero length.
		send_tick(0, 2'd0, 16'h0000, 16'h0000, 0);
		send_tick(1, 2'd2, 16'hFFFF, 16'd3, 0);
		send_tick(1, 2'd1, 16'h0001, 16'd2, 0);
		send_tick(1, 2'd0, 16'hAAAA, 16'hFFFF, 0);
		send_tick(1, 2'd3, 16'h5555, 16'd1, 0);
		send_tick(1, 2'd0, 16'h1234, 16'd0, 0);
		send_tick(1, 2'd2, 16'h0000, 16'd1, 0);
		// Overfill class one to provoke drops and a blocked requeue.
		for (int i = 0; i < 18; i++)
			send_tick(1, 2'd1, 16'(i), 16'hFFFF, 1);
		s_tvalid <= 0;
		drain_results();

		for (int p = 0; p < 8; p++) begin
			write_quantum(tlqs_pkg::CFG_QUANTUM_HIGH, qsets[p % 4][0]);
			write_quantum(tlqs_pkg::CFG_QUANTUM_MID, qsets[p % 4][1]);
			write_quantum(tlqs_pkg::CFG_QUANTUM_LOW, qsets[p % 4][2]);
			if (p == 2)
				sink_hold = 1;
			for (int i = 0; i < 190; i++)
				random_tick(p == 2 || (i % 50) < 15);
			// Sender pauses until every expected result has come.
			s_tvalid <= 0;
			drain_results();
		end

		$display("Ran %0d ticks with %0d results over several quantum settings,", tick_count,
			result_count);
		$display("including drops, preemption, rotation and a long output stall.");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
